// ===== hdl/cmt_pkg.sv =====
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared sizes, codes and control types of the counting multiset table.
// ----------------------------------------------------------------------------
package cmt_pkg;

   localparam int ENTRIES    = 64;
   localparam int ELEM_BITS  = 16;
   localparam int COUNT_BITS = 16;
   localparam int IDX_BITS   = $clog2(ENTRIES);
   localparam int FILL_BITS  = $clog2(ENTRIES + 1);

   // request codes
   localparam logic REQ_ADD    = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   // result status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [ELEM_BITS-1:0]  key;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } stat_type;

endpackage

// ===== hdl/cmt_channels.sv =====
// ----------------------------------------------------------------------------
// cmt channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cmt_req_if;
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic [cmt_pkg::ELEM_BITS-1:0]  elem_value;

   modport source (output valid, req_type, elem_value, input ready);
   modport sink   (input valid, req_type, elem_value, output ready);
endinterface

interface cmt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cmt_pkg::COUNT_BITS-1:0] elem_count;
   logic [cmt_pkg::FILL_BITS-1:0]  distinct_total;
   logic [cmt_pkg::ELEM_BITS-1:0]  popular_value;
   logic [cmt_pkg::COUNT_BITS-1:0] popular_count;
   logic                           bag_empty;
   logic                           status;

   modport source (output valid, elem_count, distinct_total, popular_value, popular_count,
                   bag_empty, status, input ready);
   modport sink   (input valid, elem_count, distinct_total, popular_value, popular_count,
                   bag_empty, status, output ready);
endinterface

// ===== hdl/cmt_datapath.sv =====
// ----------------------------------------------------------------------------
// cmt_datapath
// Entry memory, sequential key search, count update, mode tracking and the
// response register.
// ----------------------------------------------------------------------------
module cmt_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  cmt_pkg::cmd_type               cmd,
   output cmt_pkg::stat_type              stat,
   input  logic                           req_type,
   input  logic [cmt_pkg::ELEM_BITS-1:0]  elem_value,
   output logic [cmt_pkg::COUNT_BITS-1:0] elem_count,
   output logic [cmt_pkg::FILL_BITS-1:0]  distinct_total,
   output logic [cmt_pkg::ELEM_BITS-1:0]  popular_value,
   output logic [cmt_pkg::COUNT_BITS-1:0] popular_count,
   output logic                           bag_empty,
   output logic                           status
);

   // entries fill from slot 0 upwards and are never removed,
   // so the fill count marks exactly the valid slots
   cmt_pkg::entry_type mem [cmt_pkg::ENTRIES];
   cmt_pkg::entry_type rd_data_ff;

   logic [cmt_pkg::ELEM_BITS-1:0]  key_ff;
   logic                           lookup_ff;
   logic [cmt_pkg::FILL_BITS-1:0]  scan_idx_ff, scan_idx_in;
   logic                           rd_pend_ff, rd_pend_in;
   logic                           hit_ff, hit_in;
   logic [cmt_pkg::IDX_BITS-1:0]   hit_idx_ff, rd_idx_ff;
   logic [cmt_pkg::COUNT_BITS-1:0] hit_count_ff;
   logic [cmt_pkg::FILL_BITS-1:0]  distinct_ff, distinct_in;
   logic [cmt_pkg::ELEM_BITS-1:0]  best_value_ff, best_value_in;
   logic [cmt_pkg::COUNT_BITS-1:0] best_count_ff, best_count_in;

   logic [cmt_pkg::COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic [cmt_pkg::FILL_BITS-1:0]  rsp_total_ff;
   logic [cmt_pkg::ELEM_BITS-1:0]  rsp_pop_value_ff;
   logic [cmt_pkg::COUNT_BITS-1:0] rsp_pop_count_ff;
   logic                           rsp_empty_ff;
   logic                           rsp_status_ff, rsp_status_in;

   logic                           issue;
   logic                           match;
   logic                           full;
   logic                           wr_en;
   logic [cmt_pkg::IDX_BITS-1:0]   wr_idx;
   cmt_pkg::entry_type             wr_data;
   logic [cmt_pkg::COUNT_BITS-1:0] cand_count;
   logic                           take_best;

   assign issue = cmd.scan && !hit_ff && (scan_idx_ff != distinct_ff);
   assign match = rd_pend_ff && !hit_ff && (rd_data_ff.key == key_ff);
   assign full  = (distinct_ff == cmt_pkg::FILL_BITS'(cmt_pkg::ENTRIES));

   assign stat.scan_done = hit_ff || ((scan_idx_ff == distinct_ff) && !rd_pend_ff);

   always_comb begin
      scan_idx_in = scan_idx_ff;
      rd_pend_in  = 1'b0;
      hit_in      = hit_ff;
      if (cmd.start) begin
         scan_idx_in = '0;
         hit_in      = 1'b0;
      end else begin
         if (issue) begin
            scan_idx_in = scan_idx_ff + cmt_pkg::FILL_BITS'(1);
            rd_pend_in  = 1'b1;
         end
         if (match) begin
            hit_in = 1'b1;
         end
      end
   end

   // update of one entry; only that entry can overtake the current mode
   always_comb begin
      wr_en         = 1'b0;
      wr_idx        = hit_idx_ff;
      cand_count    = '0;
      distinct_in   = distinct_ff;
      rsp_count_in  = '0;
      rsp_status_in = cmt_pkg::STATUS_OK;
      if (lookup_ff == cmt_pkg::REQ_LOOKUP) begin
         rsp_count_in = hit_ff ? hit_count_ff : '0;
      end else if (hit_ff) begin
         cand_count   = (&hit_count_ff) ? hit_count_ff
                                        : hit_count_ff + cmt_pkg::COUNT_BITS'(1);
         wr_en        = 1'b1;
         rsp_count_in = cand_count;
      end else if (!full) begin
         cand_count   = cmt_pkg::COUNT_BITS'(1);
         wr_en        = 1'b1;
         wr_idx       = distinct_ff[cmt_pkg::IDX_BITS-1:0];
         distinct_in  = distinct_ff + cmt_pkg::FILL_BITS'(1);
         rsp_count_in = cand_count;
      end else begin
         rsp_status_in = cmt_pkg::STATUS_FULL;
      end
      wr_data.key   = key_ff;
      wr_data.count = cand_count;

      take_best = wr_en && ((cand_count > best_count_ff) ||
                            ((cand_count == best_count_ff) && (key_ff < best_value_ff)));
      best_value_in = take_best ? key_ff : best_value_ff;
      best_count_in = take_best ? cand_count : best_count_ff;
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= mem[scan_idx_ff[cmt_pkg::IDX_BITS-1:0]];
         rd_idx_ff  <= scan_idx_ff[cmt_pkg::IDX_BITS-1:0];
      end
      if (cmd.commit && wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff    <= elem_value;
         lookup_ff <= req_type;
      end
      if (match) begin
         hit_idx_ff   <= rd_idx_ff;
         hit_count_ff <= rd_data_ff.count;
      end
      if (cmd.commit) begin
         rsp_count_ff     <= rsp_count_in;
         rsp_total_ff     <= distinct_in;
         rsp_pop_value_ff <= (distinct_in == '0) ? '0 : best_value_in;
         rsp_pop_count_ff <= (distinct_in == '0) ? '0 : best_count_in;
         rsp_empty_ff     <= (distinct_in == '0);
         rsp_status_ff    <= rsp_status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff   <= '0;
         rd_pend_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         distinct_ff   <= '0;
         best_value_ff <= '0;
         best_count_ff <= '0;
      end else begin
         scan_idx_ff <= scan_idx_in;
         rd_pend_ff  <= rd_pend_in;
         hit_ff      <= hit_in;
         if (cmd.commit) begin
            distinct_ff   <= distinct_in;
            best_value_ff <= best_value_in;
            best_count_ff <= best_count_in;
         end
      end
   end

   assign elem_count     = rsp_count_ff;
   assign distinct_total = rsp_total_ff;
   assign popular_value  = rsp_pop_value_ff;
   assign popular_count  = rsp_pop_count_ff;
   assign bag_empty      = rsp_empty_ff;
   assign status         = rsp_status_ff;

endmodule

// ===== hdl/cmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// cmt_ctrl
// Sequencer for accept, search and commit, and the response valid flag.
// ----------------------------------------------------------------------------
module cmt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  cmt_pkg::stat_type stat,
   output cmt_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // the response register may be reloaded in the cycle it is taken
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd.start  = 1'b0;
      cmd.scan   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/counting_multiset_table_core.sv =====
// ----------------------------------------------------------------------------
// counting_multiset_table_core
// Bounded table of distinct values with occurrence counts and mode tracking.
// ----------------------------------------------------------------------------
// One request at a time: an add or lookup is taken when the core is idle, the
// stored values are searched one entry per cycle through the registered read
// port of the entry memory, and the result lands in a response register.
// The search walks the filled entries through the single read port and stops
// early at a match. A new request is taken while an earlier response still
// waits on rsp_chan. The mode is updated incrementally on each add, with ties
// going to the smaller value. A new value added to a full table is dropped
// with status set; counts saturate.
// ----------------------------------------------------------------------------
module counting_multiset_table_core (
   input  logic       clock,
   input  logic       reset,
   cmt_req_if.sink    req_chan,
   cmt_rsp_if.source  rsp_chan
);

   cmt_pkg::cmd_type  cmd;
   cmt_pkg::stat_type stat;

   cmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cmt_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_type       (req_chan.req_type),
      .elem_value     (req_chan.elem_value),
      .elem_count     (rsp_chan.elem_count),
      .distinct_total (rsp_chan.distinct_total),
      .popular_value  (rsp_chan.popular_value),
      .popular_count  (rsp_chan.popular_count),
      .bag_empty      (rsp_chan.bag_empty),
      .status         (rsp_chan.status)
   );

endmodule

// ===== hdl/cmt_checker.sv =====
// ----------------------------------------------------------------------------
// cmt_checker
// Port-level checks of the counting multiset table, bound to the top level.
// ----------------------------------------------------------------------------
module cmt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [cmt_pkg::COUNT_BITS-1:0] elem_count,
   input logic [cmt_pkg::FILL_BITS-1:0]  distinct_total,
   input logic [cmt_pkg::COUNT_BITS-1:0] popular_count,
   input logic                           bag_empty,
   input logic                           status
);

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (bag_empty == (distinct_total == '0)))
      else $error("empty flag disagrees with distinct total");

   // no stored value can outnumber the mode
   a_mode_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (elem_count <= popular_count))
      else $error("count above mode count");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == cmt_pkg::STATUS_FULL) |->
         (distinct_total == cmt_pkg::FILL_BITS'(cmt_pkg::ENTRIES)) && (elem_count == '0))
      else $error("drop reported while table not full");

endmodule

bind counting_multiset_table_core cmt_checker u_cmt_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .elem_count     (rsp_chan.elem_count),
   .distinct_total (rsp_chan.distinct_total),
   .popular_count  (rsp_chan.popular_count),
   .bag_empty      (rsp_chan.bag_empty),
   .status         (rsp_chan.status)
);
